### rtl/pwq_pkg.sv
// Package for the pixel word quadword packetizer.
// Holds the result kind codes, opcodes and the structs passed between the front and back parts.
// No dependencies.
package pwq_pkg;

  localparam int CntW = 6;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [1:0] KIND_TAG   = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_TFLSH = 2'd2;
  localparam logic [1:0] KIND_SEND  = 2'd3;

  typedef struct packed {
    logic            has_pkt;
    logic [CntW-1:0] count;
    logic            eop;
    logic            bank;
    logic            tail;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

### rtl/pwq_ram.sv
// Generic simple dual-port RAM with registered read data.
// Depends on nothing.
module pwq_ram #(
  parameter int Width = 128,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/pwq_cmd_fifo.sv
// Two-entry command queue between the front and back parts.
// Depends on pwq_pkg.
module pwq_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pwq_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output pwq_pkg::cmd_t head_o,
  output logic          empty_o,
  output logic          full_o
);
  import pwq_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);

endmodule

### rtl/pwq_front.sv
// Front part: accepts pixel transactions, marks pixels, builds quadwords into the store
// and queues packet commands. Depends on pwq_pkg.
module pwq_front #(
  parameter int PacketQwords = 32,
  parameter int AddrW        = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     tvalid_i,
  output logic                     tready_o,
  input  logic                     opcode_i,
  input  logic [31:0]              pair_i,
  output logic                     we_o,
  output logic [AddrW-1:0]         waddr_o,
  output logic [127:0]             wdata_o,
  output logic                     push_o,
  output pwq_pkg::cmd_t            cmd_o,
  input  logic                     fifo_full_i,
  input  pwq_pkg::rel_t            rel_i
);
  import pwq_pkg::*;

  function automatic logic [15:0] mark_pixel(input logic [15:0] p);
    return (p != 16'h0000) ? (p | 16'h8000) : 16'h0000;
  endfunction

  logic [31:0]     held_q [3];
  logic [1:0]      held_cnt_q, held_cnt_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic            bank_q, bank_d;
  logic [1:0]      busy_q, busy_d;

  logic            accept;
  logic            is_flush;
  logic            store_wr;
  logic [31:0]     word;
  logic [31:0]     w1, w2, w3;
  logic [CntW-1:0] fill_inc;

  assign tready_o = !busy_q[bank_q] && !fifo_full_i;
  assign accept   = tvalid_i && tready_o;
  assign is_flush = (opcode_i == OP_FLUSH);
  assign word     = {mark_pixel(pair_i[31:16]), mark_pixel(pair_i[15:0])};
  assign store_wr = accept && (is_flush ? (held_cnt_q != 2'd0) : (held_cnt_q == 2'd3));
  assign fill_inc = fill_q + CntW'(store_wr);

  assign w1 = (held_cnt_q > 2'd1) ? held_q[1] : 32'h0;
  assign w2 = (held_cnt_q > 2'd2) ? held_q[2] : 32'h0;
  assign w3 = is_flush ? 32'h0 : word;

  assign we_o    = store_wr;
  assign waddr_o = AddrW'(fill_q) + (bank_q ? AddrW'(PacketQwords) : AddrW'(0));
  assign wdata_o = {w3, w2, w1, held_q[0]};

  assign push_o        = accept && (is_flush || (store_wr && fill_inc == CntW'(PacketQwords)));
  assign cmd_o.has_pkt = (fill_inc != '0);
  assign cmd_o.count   = fill_inc;
  assign cmd_o.eop     = is_flush;
  assign cmd_o.bank    = bank_q;
  assign cmd_o.tail    = is_flush;

  always_comb begin
    held_cnt_d = held_cnt_q;
    fill_d     = store_wr ? fill_inc : fill_q;
    bank_d     = bank_q;
    busy_d     = busy_q;
    if (accept) begin
      if (is_flush || store_wr) begin
        held_cnt_d = 2'd0;
      end else begin
        held_cnt_d = held_cnt_q + 2'd1;
      end
    end
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (push_o) begin
      fill_d = '0;
      if (cmd_o.has_pkt) begin
        bank_d         = ~bank_q;
        busy_d[bank_q] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= 2'd0;
      fill_q     <= '0;
      bank_q     <= 1'b0;
      busy_q     <= 2'b00;
    end else begin
      held_cnt_q <= held_cnt_d;
      fill_q     <= fill_d;
      bank_q     <= bank_d;
      busy_q     <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !is_flush && held_cnt_q != 2'd3) begin
      held_q[held_cnt_q] <= word;
    end
  end

endmodule

### rtl/pwq_back.sv
// Back part: carries out queued commands, reads the store and drives the output register.
// Depends on pwq_pkg.
module pwq_back #(
  parameter int PacketQwords = 32,
  parameter int AddrW        = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pwq_pkg::cmd_t            head_i,
  input  logic                     empty_i,
  output logic                     pop_o,
  output logic [AddrW-1:0]         raddr_o,
  input  logic [127:0]             rdata_i,
  output pwq_pkg::rel_t            rel_o,
  output logic                     tvalid_o,
  input  logic                     tready_i,
  output logic [1:0]               kind_o,
  output logic [pwq_pkg::CntW-1:0] count_o,
  output logic                     eop_o,
  output logic [127:0]             data_o,
  output logic                     last_o
);
  import pwq_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TAG  = 3'd1;
  localparam logic [2:0] ST_DATA = 3'd2;
  localparam logic [2:0] ST_TFL  = 3'd3;
  localparam logic [2:0] ST_SEND = 3'd4;

  logic [2:0]      state_q, state_d, cur;
  logic [CntW-1:0] idx_q, idx_d;
  logic            last_data;
  logic            gen_ld;

  logic [1:0]      g_kind;
  logic            g_final;
  logic            g_rel;
  logic [AddrW-1:0] g_addr;

  logic             s1_v_q, s1_v_d;
  logic [1:0]       s1_kind_q;
  logic [CntW-1:0]  s1_count_q;
  logic             s1_eop_q;
  logic [AddrW-1:0] s1_addr_q;
  logic             s1_final_q;
  logic             s1_rel_q;
  logic             s1_bank_q;
  logic             adv;

  logic             m_v_q, m_v_d;
  logic [1:0]       m_kind_q;
  logic [CntW-1:0]  m_count_q;
  logic             m_eop_q;
  logic [127:0]     m_data_q;
  logic             m_last_q;

  assign adv    = s1_v_q && (!m_v_q || tready_i);
  assign gen_ld = !empty_i && (!s1_v_q || adv);
  assign cur    = (state_q == ST_IDLE) ? (head_i.has_pkt ? ST_TAG : ST_TFL) : state_q;
  assign last_data = (CntW'(idx_q + CntW'(1)) == head_i.count);
  assign g_addr = AddrW'(idx_q) + (head_i.bank ? AddrW'(PacketQwords) : AddrW'(0));

  always_comb begin
    g_kind  = KIND_TAG;
    g_final = 1'b0;
    g_rel   = 1'b0;
    state_d = state_q;
    idx_d   = idx_q;
    pop_o   = 1'b0;
    case (cur)
      ST_TAG: begin
        g_kind = KIND_TAG;
        if (gen_ld) begin
          state_d = ST_DATA;
          idx_d   = '0;
        end
      end
      ST_DATA: begin
        g_kind  = KIND_DATA;
        g_final = last_data && !head_i.tail;
        g_rel   = last_data;
        if (gen_ld) begin
          idx_d = idx_q + CntW'(1);
          if (last_data) begin
            if (head_i.tail) begin
              state_d = ST_TFL;
            end else begin
              state_d = ST_IDLE;
              pop_o   = 1'b1;
            end
          end
        end
      end
      ST_TFL: begin
        g_kind = KIND_TFLSH;
        if (gen_ld) begin
          state_d = ST_SEND;
        end
      end
      ST_SEND: begin
        g_kind  = KIND_SEND;
        g_final = 1'b1;
        if (gen_ld) begin
          state_d = ST_IDLE;
          pop_o   = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign raddr_o = gen_ld ? g_addr : s1_addr_q;

  always_comb begin
    s1_v_d = s1_v_q;
    if (gen_ld) begin
      s1_v_d = 1'b1;
    end else if (adv) begin
      s1_v_d = 1'b0;
    end
    m_v_d = m_v_q;
    if (adv) begin
      m_v_d = 1'b1;
    end else if (tready_i) begin
      m_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      s1_v_q  <= 1'b0;
      m_v_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      s1_v_q  <= s1_v_d;
      m_v_q   <= m_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen_ld) begin
      s1_kind_q  <= g_kind;
      s1_count_q <= (g_kind == KIND_TAG) ? head_i.count : '0;
      s1_eop_q   <= (g_kind == KIND_TAG) ? head_i.eop : 1'b0;
      s1_addr_q  <= g_addr;
      s1_final_q <= g_final;
      s1_rel_q   <= g_rel;
      s1_bank_q  <= head_i.bank;
    end
    if (adv) begin
      m_kind_q  <= s1_kind_q;
      m_count_q <= s1_count_q;
      m_eop_q   <= s1_eop_q;
      m_data_q  <= (s1_kind_q == KIND_DATA) ? rdata_i : 128'h0;
      m_last_q  <= s1_final_q;
    end
  end

  assign rel_o.valid = adv && s1_rel_q;
  assign rel_o.bank  = s1_bank_q;

  assign tvalid_o = m_v_q;
  assign kind_o   = m_kind_q;
  assign count_o  = m_count_q;
  assign eop_o    = m_eop_q;
  assign data_o   = m_data_q;
  assign last_o   = m_last_q;

endmodule

### rtl/pixel_word_qword_packetizer.sv
// Top level of the pixel word quadword packetizer.
// Depends on pwq_pkg, pwq_front, pwq_cmd_fifo, pwq_back and pwq_ram.
//
//   Port group  Role    tdata / tuser / tlast
//   s_axis      in      pixel_pair / opcode / none
//   m_axis      out     qword_count, end_of_packet, data_low, data_high / kind / final_res
//
// The front accepts one pixel transaction per cycle while the store bank it writes is free
// and the two-entry command queue has room; two store banks alternate between packets.
// The back issues one result per cycle unless the output stalls, through a store read
// stage and an output register; N quadwords give N + 1 results, plus two for a flush.
// Reset clears all control state at once; there is no clearing pass.
// Input stalls while the back still drains the bank that the front wants to fill.
module pixel_word_qword_packetizer #(
  parameter int PACKET_QWORDS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // pixel_pair
  input  logic         s_axis_tuser,   // opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,   // qword_count, end_of_packet, data_low, data_high, pad
  output logic [1:0]   m_axis_tuser,   // kind
  output logic         m_axis_tlast    // final_res
);
  import pwq_pkg::*;

  localparam int Depth = 2 * PACKET_QWORDS;
  localparam int AddrW = $clog2(Depth);

  logic             we;
  logic [AddrW-1:0] waddr;
  logic [127:0]     wdata;
  logic [AddrW-1:0] raddr;
  logic [127:0]     rdata;
  logic             push;
  logic             pop;
  logic             fifo_full;
  logic             fifo_empty;
  cmd_t             cmd;
  cmd_t             head;
  rel_t             rel;
  logic [CntW-1:0]  count;
  logic             eop;
  logic [127:0]     data;

  pwq_front #(
    .PacketQwords(PACKET_QWORDS),
    .AddrW       (AddrW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tvalid_i   (s_axis_tvalid),
    .tready_o   (s_axis_tready),
    .opcode_i   (s_axis_tuser),
    .pair_i     (s_axis_tdata),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .push_o     (push),
    .cmd_o      (cmd),
    .fifo_full_i(fifo_full),
    .rel_i      (rel)
  );

  pwq_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .pop_i  (pop),
    .head_o (head),
    .empty_o(fifo_empty),
    .full_o (fifo_full)
  );

  pwq_ram #(
    .Width(128),
    .Depth(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  pwq_back #(
    .PacketQwords(PACKET_QWORDS),
    .AddrW       (AddrW)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (fifo_empty),
    .pop_o   (pop),
    .raddr_o (raddr),
    .rdata_i (rdata),
    .rel_o   (rel),
    .tvalid_o(m_axis_tvalid),
    .tready_i(m_axis_tready),
    .kind_o  (m_axis_tuser),
    .count_o (count),
    .eop_o   (eop),
    .data_o  (data),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, data, eop, count};

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && fifo_full))
    else $error("Command queue overflow.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !fifo_empty) || !pop)
    else $error("Command queue popped while empty.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_TAG) |->
      (count != '0 && count <= CntW'(PACKET_QWORDS)))
    else $error("Image tag with an out-of-range quadword count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_SEND) |-> m_axis_tlast)
    else $error("Send marker without the last-result mark.");

endmodule
